/* rtl/md5_pkg.sv */
// Package: MD5 engine types, constants and round tables.
`default_nettype none
package md5_pkg;
    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } md5_req_t;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } md5_rsp_t;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    typedef struct packed {
        logic       put_byte;
        logic [7:0] put_data;
        logic       count_inc;
        logic       clear_tail;
        logic       clear_all;
        logic       put_length;
        logic       comp_start;
        logic       comp_step;
        logic       comp_done;
        logic       reinit;
    } md5_cmd_t;

    typedef struct packed {
        logic [5:0] pos;
        logic [5:0] round;
    } md5_sts_t;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [3:0] idx);
        logic [4:0] s;
        unique case (idx)
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction
endpackage
`default_nettype wire

/* rtl/md5_ctrl.sv */
// Controller: request sequencing, padding steps and compression rounds.
`default_nettype none
module md5_ctrl
    import md5_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire md5_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire md5_sts_t sts,
    output md5_cmd_t      cmd
);
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_COMP  = 6'b000010,
        ST_PADC  = 6'b000100,
        ST_LEN   = 6'b001000,
        ST_LCOMP = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.put_data = s_data.data_byte;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.command == CMD_ABSORB) begin
                        cmd.put_byte  = 1'b1;
                        cmd.count_inc = 1'b1;
                        if (sts.pos == 6'd63) begin
                            cmd.comp_start = 1'b1;
                            state_next     = ST_COMP;
                        end
                    end else begin
                        cmd.put_byte   = 1'b1;
                        cmd.put_data   = PAD_BYTE;
                        cmd.clear_tail = 1'b1;
                        if (sts.pos >= LEN_POS) begin
                            cmd.comp_start = 1'b1;
                            state_next     = ST_PADC;
                        end else begin
                            state_next = ST_LEN;
                        end
                    end
                end
            end
            ST_COMP, ST_PADC, ST_LCOMP: begin
                cmd.comp_step = 1'b1;
                if (sts.round == 6'd63) begin
                    cmd.comp_done = 1'b1;
                    unique case (state_reg)
                        ST_PADC: begin
                            cmd.clear_all = 1'b1;
                            state_next    = ST_LEN;
                        end
                        ST_LCOMP: state_next = ST_OUT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LEN: begin
                cmd.put_length = 1'b1;
                cmd.comp_start = 1'b1;
                state_next     = ST_LCOMP;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.reinit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_round_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.comp_start |=> sts.round == 6'd0) else $error("round not reset");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
`endif
endmodule
`default_nettype wire

/* rtl/md5_dp.sv */
// Datapath: block buffer, byte count, chaining words and the round unit.
`default_nettype none
module md5_dp
    import md5_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire md5_cmd_t cmd,
    output md5_sts_t      sts,
    output md5_rsp_t      rsp
);
    logic [31:0] blk_reg [16];
    logic [31:0] blk_next [16];
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [63:0] count_reg, count_next;
    logic [5:0]  round_reg, round_next;
    logic [63:0] bits;
    logic [31:0] f, sum, rot, m;
    logic [3:0]  g;
    logic [4:0]  s;
    logic [1:0]  phase;
    logic [5:0]  pos;

    assign pos   = count_reg[5:0];
    assign bits  = {count_reg[60:0], 3'b000};
    assign phase = round_reg[5:4];
    assign sts.pos   = pos;
    assign sts.round = round_reg;

    always_comb begin
        unique case (phase)
            2'd0: begin
                f = d_reg ^ (b_reg & (c_reg ^ d_reg));
                g = round_reg[3:0];
            end
            2'd1: begin
                f = c_reg ^ (d_reg & (b_reg ^ c_reg));
                g = 4'(round_reg * 6'd5 + 6'd1);
            end
            2'd2: begin
                f = b_reg ^ c_reg ^ d_reg;
                g = 4'(round_reg * 6'd3 + 6'd5);
            end
            default: begin
                f = c_reg ^ (b_reg | ~d_reg);
                g = 4'(round_reg * 6'd7);
            end
        endcase
        m   = blk_reg[g];
        s   = md5_s({phase, round_reg[1:0]});
        sum = a_reg + f + md5_k(round_reg) + m;
        rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    end

    always_comb begin
        blk_next   = blk_reg;
        chain_next = chain_reg;
        count_next = count_reg;
        round_next = round_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; d_next = d_reg;
        if (cmd.put_byte) begin
            blk_next[pos[5:2]][8*pos[1:0] +: 8] = cmd.put_data;
        end
        if (cmd.clear_tail) begin
            for (int n = 0; n < 64; n++) begin
                if (6'(n) > pos) begin
                    blk_next[n/4][8*(n%4) +: 8] = 8'h00;
                end
            end
        end
        if (cmd.count_inc) begin
            count_next = count_reg + 64'd1;
        end
        if (cmd.put_length) begin
            blk_next[14] = bits[31:0];
            blk_next[15] = bits[63:32];
        end
        if (cmd.comp_start) begin
            round_next = '0;
            a_next = chain_reg[0]; b_next = chain_reg[1];
            c_next = chain_reg[2]; d_next = chain_reg[3];
        end
        if (cmd.comp_step) begin
            round_next = round_reg + 6'd1;
            a_next = d_reg;
            d_next = c_reg;
            c_next = b_reg;
            b_next = b_reg + rot;
        end
        if (cmd.comp_done) begin
            chain_next[0] = chain_reg[0] + d_reg;
            chain_next[1] = chain_reg[1] + b_reg + rot;
            chain_next[2] = chain_reg[2] + b_reg;
            chain_next[3] = chain_reg[3] + c_reg;
        end
        if (cmd.clear_all) begin
            for (int n = 0; n < 16; n++) begin
                blk_next[n] = '0;
            end
        end
        if (cmd.reinit) begin
            for (int n = 0; n < 16; n++) begin
                blk_next[n] = '0;
            end
            chain_next[0] = IV_A; chain_next[1] = IV_B;
            chain_next[2] = IV_C; chain_next[3] = IV_D;
            count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < 16; n++) begin
                blk_reg[n] <= '0;
            end
            chain_reg[0] <= IV_A; chain_reg[1] <= IV_B;
            chain_reg[2] <= IV_C; chain_reg[3] <= IV_D;
            count_reg <= '0;
            round_reg <= '0;
        end else begin
            blk_reg   <= blk_next;
            chain_reg <= chain_next;
            count_reg <= count_next;
            round_reg <= round_next;
        end
        a_reg <= a_next; b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
    end

    assign rsp.digest_low  = {chain_reg[1], chain_reg[0]};
    assign rsp.digest_high = {chain_reg[3], chain_reg[2]};

`ifndef ASSERT_OFF
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.count_inc && !cmd.reinit |=> count_reg == $past(count_reg) + 64'd1)
        else $error("count step");
    a_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.reinit |=> chain_reg[0] == IV_A && count_reg == 64'd0)
        else $error("reinit");
    a_round_adv: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.comp_step && !cmd.comp_start |=> round_reg == $past(round_reg) + 6'd1)
        else $error("round step");
`endif
endmodule
`default_nettype wire

/* rtl/md5_hash_engine.sv */
// Top level: MD5 engine, controller plus datapath.
`default_nettype none
// An absorb request writes its byte into the block buffer; the 64th byte of a block then
// holds s_ready low for the 64 compression rounds (one round per cycle in a single
// round unit). A finish request runs one or two compressions of 64 rounds each plus
// a length setup step before the digest appears.
// The digest is presented until m_ready; the engine then returns to its initial
// vector and takes a new message on the next cycle.
module md5_hash_engine
    import md5_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire md5_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output md5_rsp_t      m_data
);
    md5_cmd_t cmd;
    md5_sts_t sts;

    md5_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    md5_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .sts(sts), .rsp(m_data)
    );
endmodule
`default_nettype wire
